// ===== rtl/gua_pkg.sv =====
// Shared types for the stable ascending grade block.
`timescale 1ns / 1ps
`default_nettype none
package gua_pkg;

  localparam int unsigned ValueW = 32;
  localparam int unsigned PosW   = 6;

  // One stored element: its value and its arrival position.
  typedef struct packed {
    logic [ValueW-1:0] value;
    logic [PosW-1:0]   pos;
  } entry_t;

  // Per-cycle command broadcast to every cell of the chain.
  typedef struct packed {
    logic insert;  // place the broadcast element into the sorted row
    logic drain;   // shift the row one place toward cell 0
  } cell_ctrl_t;

endpackage
`default_nettype wire

// ===== rtl/grade_up_argsort_core.sv =====
// Top level of the stable ascending grade (argsort) block.
`timescale 1ns / 1ps
`default_nettype none
// Elements stream in one per cycle (start high while busy is low) and are
// kept in ascending order by a row of MAX_LEN cells: each accepted element is
// compared against every cell at once and the cells above its place shift up
// by one, so one element is taken every cycle. Elements beyond MAX_LEN before
// the one flagged last are dropped. The cycle after the last element is taken,
// busy rises and the grade leaves at one index per cycle from cell 0 while the
// row shifts down, with out_final_index on the final one. Results appear on
// out_valid for a single cycle and cannot be held off; busy falls in the cycle
// after the final index.
module grade_up_argsort_core #(
  parameter int unsigned MAX_LEN = 64
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  output logic                           busy,
  input  wire logic [gua_pkg::ValueW-1:0] in_element_value,
  input  wire logic                      in_is_last,
  output logic                           out_valid,
  output logic [gua_pkg::PosW-1:0]       out_original_position,
  output logic                           out_final_index
);

  localparam int unsigned CntW = $clog2(MAX_LEN + 1);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EMIT = 2'b10
  } state_t;

  state_t              state_r, state_nxt;
  logic [CntW-1:0]     count_r, count_nxt;

  logic                accept;
  logic                do_insert;
  gua_pkg::cell_ctrl_t ctrl;
  gua_pkg::entry_t     new_entry;
  gua_pkg::entry_t     entries [MAX_LEN];
  logic                greater [MAX_LEN];

  assign busy      = (state_r == ST_EMIT);
  assign accept    = start && !busy;
  assign do_insert = accept && (count_r < CntW'(MAX_LEN));

  assign ctrl.insert     = do_insert;
  assign ctrl.drain      = busy;
  assign new_entry.value = in_element_value;
  assign new_entry.pos   = gua_pkg::PosW'(count_r);

  // Build the chain of cells
  for (genvar i = 0; i < MAX_LEN; i++) begin : g_cell
    gua_pkg::entry_t left_e;
    gua_pkg::entry_t right_e;
    logic            left_g;

    if (i == 0) begin : g_first
      assign left_e = '0;
      assign left_g = 1'b0;
    end else begin : g_mid
      assign left_e = entries[i-1];
      assign left_g = greater[i-1];
    end

    if (i == MAX_LEN - 1) begin : g_last
      assign right_e = '0;
    end else begin : g_inner
      assign right_e = entries[i+1];
    end

    gua_cell u_cell (
      .clk          (clk),
      .ctrl         (ctrl),
      .new_entry    (new_entry),
      .left_entry   (left_e),
      .left_greater (left_g),
      .right_entry  (right_e),
      .occupied     (CntW'(i) < count_r),
      .at_end       (CntW'(i) == count_r),
      .entry        (entries[i]),
      .greater      (greater[i])
    );
  end

  // Emit from the head of the row
  assign out_valid             = busy;
  assign out_original_position = entries[0].pos;
  assign out_final_index       = busy && (count_r == CntW'(1));

  // Sequence collection and emission
  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    unique case (state_r)
      ST_IDLE: begin
        if (do_insert) begin
          count_nxt = count_r + CntW'(1);
        end
        if (accept && in_is_last) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        count_nxt = count_r - CntW'(1);
        if (count_r == CntW'(1)) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
        count_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  // The grade starts the cycle after the last element is taken
  a_emit_follows_last: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_is_last |=> out_valid)
    else $error("grade did not start after last element");

  // Emission stops right after the final index
  a_final_ends_emit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_final_index |=> !busy && count_r == '0)
    else $error("emission continued past final index");

  // A non-final index is always followed by another
  a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_final_index |=> out_valid)
    else $error("grade broke off before final index");

  // Never emit from an empty row, never overfill
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r <= CntW'(MAX_LEN)) && (!busy || count_r != '0))
    else $error("element count out of range");

  // Head of the row stays in ascending order
  a_sorted_head: assert property (@(posedge clk) disable iff (!rst_n)
    !busy && count_r >= CntW'(2) |->
      $signed(entries[0].value) <= $signed(entries[1].value))
    else $error("sorted row out of order");

endmodule
`default_nettype wire

// ===== rtl/gua_cell.sv =====
// One cell of the insertion chain: holds one sorted entry.
`timescale 1ns / 1ps
`default_nettype none
module gua_cell (
  input  wire logic                clk,
  input  wire gua_pkg::cell_ctrl_t ctrl,
  input  wire gua_pkg::entry_t     new_entry,
  input  wire gua_pkg::entry_t     left_entry,
  input  wire logic                left_greater,
  input  wire gua_pkg::entry_t     right_entry,
  input  wire logic                occupied,
  input  wire logic                at_end,
  output gua_pkg::entry_t          entry,
  output logic                     greater
);

  gua_pkg::entry_t entry_r;
  gua_pkg::entry_t entry_nxt;

  // Strictly greater keeps ties in arrival order.
  assign greater = occupied &&
                   ($signed(entry_r.value) > $signed(new_entry.value));
  assign entry   = entry_r;

  // Pick the next content: shift in from either neighbor or take the new element
  always_comb begin
    entry_nxt = entry_r;
    if (ctrl.drain) begin
      entry_nxt = right_entry;
    end else if (ctrl.insert) begin
      if (left_greater) begin
        entry_nxt = left_entry;
      end else if (greater || at_end) begin
        entry_nxt = new_entry;
      end
    end
  end

  // Hold payload; no reset needed
  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule
`default_nettype wire

// ===== bench/grade_checker.sv =====
// Checker for the stable ascending grade block: predicts each grade and compares results.
`timescale 1ns / 1ps
module grade_checker #(
  parameter int unsigned MAX_LEN = 64
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic                       busy,
  input  logic [gua_pkg::ValueW-1:0] in_element_value,
  input  logic                       in_is_last,
  input  logic                       out_valid,
  input  logic [gua_pkg::PosW-1:0]   out_original_position,
  input  logic                       out_final_index,
  output int                         fail_count,
  output int                         indices_pending,
  output int                         indices_checked
);

  // One index of a grade as it should leave the block.
  typedef struct packed {
    logic [gua_pkg::PosW-1:0] pos;
    logic                     last;
  } grade_idx_t;

  // Shadow of the sorted row: values ascending, ties in arrival order.
  logic signed [gua_pkg::ValueW-1:0] row_value [MAX_LEN];
  logic [gua_pkg::PosW-1:0]          row_pos   [MAX_LEN];
  int unsigned                       row_count;
  grade_idx_t                        expected_grade [$];

  always @(posedge clk) begin : watch
    grade_idx_t                        want;
    int unsigned                       slot;
    int                                errs;
    logic signed [gua_pkg::ValueW-1:0] value;
    errs = 0;
    if (!rst_n) begin
      expected_grade.delete();
      row_count = 0;
      fail_count <= 0;
      indices_pending <= 0;
      indices_checked <= 0;
    end else begin
      // Compare each emitted index against the oldest expected one
      if (out_valid) begin
        if (expected_grade.size() == 0) begin
          $error("unexpected result: original_position %0d, final_index %0b with nothing pending",
                 out_original_position, out_final_index);
          errs++;
        end else begin
          want = expected_grade.pop_front();
          if (out_original_position !== want.pos) begin
            $error("original_position mismatch: expected %0d, actual %0d",
                   want.pos, out_original_position);
            errs++;
          end
          if (out_final_index !== want.last) begin
            $error("final_index mismatch: expected %0b, actual %0b",
                   want.last, out_final_index);
            errs++;
          end
        end
        indices_checked <= indices_checked + 1;
      end

      // Insert each accepted request behind every stored value that is not larger
      if (start && !busy) begin
        value = $signed(in_element_value);
        if (row_count < MAX_LEN) begin
          slot = row_count;
          while (slot > 0 && row_value[slot-1] > value) begin
            row_value[slot] = row_value[slot-1];
            row_pos[slot]   = row_pos[slot-1];
            slot--;
          end
          row_value[slot] = value;
          row_pos[slot]   = gua_pkg::PosW'(row_count);
          row_count++;
        end
        // Emit the whole grade on the last element, then start a new vector
        if (in_is_last) begin
          for (int unsigned k = 0; k < row_count; k++) begin
            expected_grade.push_back(grade_idx_t'{pos: row_pos[k], last: (k + 1 == row_count)});
          end
          row_count = 0;
        end
      end

      fail_count <= fail_count + errs;
      indices_pending <= expected_grade.size();
    end
  end

endmodule

// ===== bench/testbench.sv =====
// Top of the grade block bench: clock, reset, element stimulus and verdict.
`timescale 1ns / 1ps
module testbench;

  localparam int unsigned GradeDepth = 64;
  localparam int          TargetKept = 400;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       start = 1'b0;
  logic                       busy;
  logic [gua_pkg::ValueW-1:0] in_element_value = '0;
  logic                       in_is_last = 1'b0;
  logic                       out_valid;
  logic [gua_pkg::PosW-1:0]   out_original_position;
  logic                       out_final_index;

  int fail_count;
  int indices_pending;
  int indices_checked;

  logic [gua_pkg::ValueW-1:0] vec_values [$];
  bit                         burst_mode;
  int                         elements_sent;
  int                         elements_kept;
  int                         vectors_sent;
  int                         overflow_vectors;
  int                         pauses;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  grade_up_argsort_core #(
    .MAX_LEN(GradeDepth)
  ) u_top (
    .clk                  (clk),
    .rst_n                (rst_n),
    .start                (start),
    .busy                 (busy),
    .in_element_value     (in_element_value),
    .in_is_last           (in_is_last),
    .out_valid            (out_valid),
    .out_original_position(out_original_position),
    .out_final_index      (out_final_index)
  );

  grade_checker #(
    .MAX_LEN(GradeDepth)
  ) u_checker (
    .clk                  (clk),
    .rst_n                (rst_n),
    .start                (start),
    .busy                 (busy),
    .in_element_value     (in_element_value),
    .in_is_last           (in_is_last),
    .out_valid            (out_valid),
    .out_original_position(out_original_position),
    .out_final_index      (out_final_index),
    .fail_count           (fail_count),
    .indices_pending      (indices_pending),
    .indices_checked      (indices_checked)
  );

  // Hold one request until the block takes it, then idle for a random, possibly empty gap unless in burst mode
  task automatic send_element(input logic [gua_pkg::ValueW-1:0] value, input logic last);
    int gap;
    in_element_value <= value;
    in_is_last <= last;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    elements_sent++;
    gap = burst_mode ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Send the queued vector, flagging its final element
  task automatic send_vector();
    for (int i = 0; i < vec_values.size(); i++) begin
      send_element(vec_values[i], i == vec_values.size() - 1);
    end
    elements_kept += (vec_values.size() > GradeDepth) ? GradeDepth : vec_values.size();
    if (vec_values.size() > GradeDepth) overflow_vectors++;
    vectors_sent++;
    vec_values.delete();
  endtask

  // Drop start and wait until every expected index has come out
  task automatic drain_grades();
    start <= 1'b0;
    do @(posedge clk); while (indices_pending != 0);
    pauses++;
  endtask

  // Draw one element value in the given style
  function automatic logic [gua_pkg::ValueW-1:0] draw_value(input int style);
    case (style)
      0: draw_value = gua_pkg::ValueW'($urandom_range(0, 7)) - gua_pkg::ValueW'(4);
      1: begin
        case ($urandom_range(0, 5))
          0: draw_value = 32'h7FFF_FFFF;
          1: draw_value = 32'h8000_0000;
          2: draw_value = 32'hFFFF_FFFF;
          3: draw_value = 32'h0000_0000;
          4: draw_value = 32'h0000_0001;
          default: draw_value = $urandom();
        endcase
      end
      default: draw_value = $urandom();
    endcase
  endfunction

  initial begin : stimulus
    int len;
    int style;
    int pick;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: single element, signed extremes, ties, reverse order, all equal
    vec_values = '{32'h0000_0000};
    send_vector();
    vec_values = '{32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0000_0000,
                   32'h0000_0001, 32'h8000_0001, 32'h7FFF_FFFE};
    send_vector();
    vec_values = '{32'd5, 32'd5, -32'sd3, 32'd5, -32'sd3, 32'd5};
    send_vector();
    drain_grades();
    burst_mode = 1'b1;
    vec_values = '{32'd3, 32'd2, 32'd1, 32'd0};
    send_vector();
    vec_values = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
    send_vector();
    burst_mode = 1'b0;

    // Random vectors: mostly short, some exactly full, some overflowing the store
    while (elements_kept < 21 + TargetKept) begin
      pick = $urandom_range(0, 99);
      if (vectors_sent == 7) len = GradeDepth + $urandom_range(1, 6);
      else if (vectors_sent == 10) len = GradeDepth;
      else if (pick < 65) len = $urandom_range(1, 8);
      else if (pick < 85) len = $urandom_range(9, 40);
      else if (pick < 93) len = GradeDepth;
      else len = $urandom_range(GradeDepth + 1, GradeDepth + 8);
      style = $urandom_range(0, 2);
      burst_mode = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < len; i++) vec_values.push_back(draw_value(style));
      send_vector();
      if ($urandom_range(0, 4) == 0) drain_grades();
    end

    // Let the last grade drain, then watch for stray results
    drain_grades();
    repeat (80) @(posedge clk);
    $display("covered %0d vectors (%0d past a full store), %0d elements, %0d indices checked",
             vectors_sent, overflow_vectors, elements_sent, indices_checked);
    $display("sender paused for an empty pipeline %0d times", pauses);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Stop a hung run
  initial begin : watchdog
    #5_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
